// ===== rtl/core/cmtc_pkg.sv =====
package cmtc_pkg;

    // motor mode codes
    localparam logic [2:0] MODE_STOP      = 3'd0;
    localparam logic [2:0] MODE_OPEN      = 3'd1;
    localparam logic [2:0] MODE_CLOSE     = 3'd2;
    localparam logic [2:0] MODE_GAP_OPEN  = 3'd3;
    localparam logic [2:0] MODE_GAP_CLOSE = 3'd4;

    // tick kinds
    localparam logic OP_KEY   = 1'b0;
    localparam logic OP_RELAY = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_BASELINE0 = 3'd0;
    localparam logic [2:0] REG_BASELINE1 = 3'd1;
    localparam logic [2:0] REG_BASELINE2 = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_RUN_TICKS = 3'd4;
    localparam logic [2:0] REG_GAP_TICKS = 3'd5;

    // reset values of the configuration registers
    localparam logic [15:0] THRESHOLD_RST = 16'd10;
    localparam logic [9:0]  RUN_TICKS_RST = 10'd600;
    localparam logic [9:0]  GAP_TICKS_RST = 10'd5;

    // hold counting
    localparam logic [12:0] WIN_LO      = 13'd3000;
    localparam logic [12:0] WIN_HI      = 13'd4500;
    localparam logic [12:0] TRIPLE_SAT  = 13'd4501;
    localparam logic [2:0]  SINGLE_SAT  = 3'd7;
    localparam logic [2:0]  FIRE_HOLD   = 3'd4;

    // led blink
    localparam logic [3:0] BLINK_LAST    = 4'd9;
    localparam logic [3:0] BLINK_ON_FROM = 4'd5;

    typedef struct packed {
        logic [15:0] baseline0;
        logic [15:0] baseline1;
        logic [15:0] baseline2;
        logic [15:0] threshold;
        logic [9:0]  run_ticks;
        logic [9:0]  gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       restart;
    } key_res_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] levels;
        logic       led;
        logic       changed;
    } relay_res_t;

    function automatic logic in_window(input logic [12:0] t);
        return (t >= WIN_LO) && (t <= WIN_HI);
    endfunction

endpackage

// ===== rtl/core/curtain_motor_touch_controller.sv =====
// curtain motor touch controller: takes one tick item per clock cycle when the output
// side does not stall and gives one result item for each, held first in the input
// register and then in the result register, which holds it while the output stalls.
// a key tick (opcode 0) samples the three touch pads against their baselines and
// updates the hold counters and motor mode; a relay tick (opcode 1) drives the
// relays, runs the run/gap countdown and steps the led blink. the rate is set by
// the single pass of logic between the input register and the result register,
// which also updates the motor state, so consecutive items see each other's
// effects exactly in order. configuration is to be written through cfg_we/cfg_index/
// cfg_wdata only while no item is in flight; the block does not enforce this. unknown indexes are ignored.
module curtain_motor_touch_controller (
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] pad_value0,
    input  logic [15:0] pad_value1,
    input  logic [15:0] pad_value2,

    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic        relay_open,
    output logic        relay_close,
    output logic        leds_on,
    output logic [2:0]  motor_mode,
    output logic        state_changed,
    output logic        restart_request
);

    cmtc_pkg::cfg_t       cfg_reg;
    cmtc_pkg::key_res_t   key_res;
    cmtc_pkg::relay_res_t relay_res;

    // input register stage
    logic        s1_valid_reg;
    logic        s1_opcode_reg;
    logic [15:0] s1_pad0_reg;
    logic [15:0] s1_pad1_reg;
    logic [15:0] s1_pad2_reg;

    // result register stage
    logic        out_valid_reg;
    logic        relay_open_reg;
    logic        relay_close_reg;
    logic        leds_on_reg;
    logic        state_changed_reg;
    logic        restart_request_reg;

    logic [2:0]  mode_reg;
    logic [2:0]  mode_next;

    logic        advance;
    logic        accept;
    logic        fire;
    logic        key_fire;
    logic        relay_fire;
    logic        flash;

    // result stage can take a new item when empty or being drained
    assign advance    = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign fire       = s1_valid_reg && advance;
    assign key_fire   = fire && (s1_opcode_reg == cmtc_pkg::OP_KEY);
    assign relay_fire = fire && (s1_opcode_reg == cmtc_pkg::OP_RELAY);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baseline0 <= '0;
            cfg_reg.baseline1 <= '0;
            cfg_reg.baseline2 <= '0;
            cfg_reg.threshold <= cmtc_pkg::THRESHOLD_RST;
            cfg_reg.run_ticks <= cmtc_pkg::RUN_TICKS_RST;
            cfg_reg.gap_ticks <= cmtc_pkg::GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmtc_pkg::REG_BASELINE0: cfg_reg.baseline0 <= cfg_wdata;
                cmtc_pkg::REG_BASELINE1: cfg_reg.baseline1 <= cfg_wdata;
                cmtc_pkg::REG_BASELINE2: cfg_reg.baseline2 <= cfg_wdata;
                cmtc_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_wdata;
                cmtc_pkg::REG_RUN_TICKS: cfg_reg.run_ticks <= cfg_wdata[9:0];
                cmtc_pkg::REG_GAP_TICKS: cfg_reg.gap_ticks <= cfg_wdata[9:0];
                default:                 ;
            endcase
        end
    end

    // input register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input register: payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg <= opcode;
            s1_pad0_reg   <= pad_value0;
            s1_pad1_reg   <= pad_value1;
            s1_pad2_reg   <= pad_value2;
        end
    end

    cmtc_key_unit u_key (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (key_fire),
        .pad0  (s1_pad0_reg),
        .pad1  (s1_pad1_reg),
        .pad2  (s1_pad2_reg),
        .cfg   (cfg_reg),
        .mode  (mode_reg),
        .res   (key_res),
        .flash (flash)
    );

    cmtc_relay_unit u_relay (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (relay_fire),
        .cfg   (cfg_reg),
        .mode  (mode_reg),
        .flash (flash),
        .res   (relay_res)
    );

    // motor mode is shared: key ticks pick a new direction, relay ticks time it out
    assign mode_next = (s1_opcode_reg == cmtc_pkg::OP_RELAY) ? relay_res.mode : key_res.mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cmtc_pkg::MODE_STOP;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
        end
    end

    // result register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register: payload, loaded with the state after the tick
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            relay_open_reg      <= relay_res.levels[0];
            relay_close_reg     <= relay_res.levels[1];
            leds_on_reg         <= relay_res.led;
            state_changed_reg   <= relay_res.changed;
            restart_request_reg <= key_fire && key_res.restart;
        end
    end

    // motor_mode output shows the mode register, which only moves with a result
    assign out_valid       = out_valid_reg;
    assign relay_open      = relay_open_reg;
    assign relay_close     = relay_close_reg;
    assign leds_on         = leds_on_reg;
    assign motor_mode      = mode_reg;
    assign state_changed   = state_changed_reg;
    assign restart_request = restart_request_reg;

endmodule

// ===== rtl/core/cmtc_key_unit.sv =====
module cmtc_key_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [15:0]         pad0,
    input  logic [15:0]         pad1,
    input  logic [15:0]         pad2,
    input  cmtc_pkg::cfg_t      cfg,
    input  logic [2:0]          mode,
    output cmtc_pkg::key_res_t  res,
    output logic                flash
);

    logic [2:0]  touched;
    logic [15:0] pad   [3];
    logic [15:0] base  [3];
    logic [15:0] diff  [3];
    logic [2:0]  single_hold_reg  [3];
    logic [2:0]  single_hold_next [3];
    logic [12:0] triple_hold_reg;
    logic [12:0] triple_hold_next;
    logic        flash_reg;
    logic        flash_next;
    logic        restart;
    logic [2:0]  mode_next;

    assign pad[0]  = pad0;
    assign pad[1]  = pad1;
    assign pad[2]  = pad2;
    assign base[0] = cfg.baseline0;
    assign base[1] = cfg.baseline1;
    assign base[2] = cfg.baseline2;

    // touch: reading strictly below baseline by at least the threshold
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k]    = base[k] - pad[k];
            touched[k] = (base[k] > pad[k]) && (diff[k] >= cfg.threshold);
        end
    end

    always_comb
    begin
        restart          = 1'b0;
        flash_next       = 1'b0;
        triple_hold_next = '0;
        mode_next        = mode;
        for (int k = 0; k < 3; k++)
        begin
            single_hold_next[k] = '0;
        end

        if ($onehot(touched))
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (touched[k])
                begin
                    single_hold_next[k] = (single_hold_reg[k] < cmtc_pkg::SINGLE_SAT)
                                        ? single_hold_reg[k] + 3'd1
                                        : single_hold_reg[k];
                end
            end
            priority if (single_hold_next[0] == cmtc_pkg::FIRE_HOLD)
            begin
                if (mode == cmtc_pkg::MODE_STOP || mode == cmtc_pkg::MODE_GAP_CLOSE)
                    mode_next = cmtc_pkg::MODE_OPEN;
                else if (mode == cmtc_pkg::MODE_CLOSE)
                    mode_next = cmtc_pkg::MODE_GAP_OPEN;
            end
            else if (single_hold_next[1] == cmtc_pkg::FIRE_HOLD)
            begin
                mode_next = cmtc_pkg::MODE_STOP;
            end
            else if (single_hold_next[2] == cmtc_pkg::FIRE_HOLD)
            begin
                if (mode == cmtc_pkg::MODE_STOP || mode == cmtc_pkg::MODE_GAP_OPEN)
                    mode_next = cmtc_pkg::MODE_CLOSE;
                else if (mode == cmtc_pkg::MODE_OPEN)
                    mode_next = cmtc_pkg::MODE_GAP_CLOSE;
            end
            else
            begin
                mode_next = mode;
            end
        end
        else if (&touched)
        begin
            triple_hold_next = (triple_hold_reg < cmtc_pkg::TRIPLE_SAT)
                             ? triple_hold_reg + 13'd1
                             : triple_hold_reg;
            flash_next       = cmtc_pkg::in_window(triple_hold_next);
        end
        else
        begin
            // none or two keys: release, restart if let go inside the window
            restart = cmtc_pkg::in_window(triple_hold_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            triple_hold_reg <= '0;
            flash_reg       <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                single_hold_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            triple_hold_reg <= triple_hold_next;
            flash_reg       <= flash_next;
            for (int k = 0; k < 3; k++)
            begin
                single_hold_reg[k] <= single_hold_next[k];
            end
        end
    end

    assign res.mode    = mode_next;
    assign res.restart = restart;
    assign flash       = flash_reg;

endmodule

// ===== rtl/core/cmtc_relay_unit.sv =====
module cmtc_relay_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  cmtc_pkg::cfg_t        cfg,
    input  logic [2:0]            mode,
    input  logic                  flash,
    output cmtc_pkg::relay_res_t  res
);

    logic [2:0] last_seen_reg;
    logic [9:0] countdown_reg;
    logic [9:0] countdown_load;
    logic [9:0] countdown_next;
    logic [1:0] levels_reg;
    logic [1:0] levels_next;
    logic [3:0] blink_reg;
    logic [3:0] blink_next;
    logic       led_reg;
    logic       led_next;
    logic       changed;
    logic       running;
    logic [2:0] mode_next;

    assign changed = (last_seen_reg != mode);
    assign running = (mode == cmtc_pkg::MODE_OPEN) || (mode == cmtc_pkg::MODE_CLOSE);

    always_comb
    begin
        countdown_load = countdown_reg;
        levels_next    = levels_reg;
        mode_next      = mode;
        if (changed)
        begin
            countdown_load = running ? cfg.run_ticks : cfg.gap_ticks;
            unique case (mode)
                cmtc_pkg::MODE_OPEN:  levels_next = 2'b01;
                cmtc_pkg::MODE_CLOSE: levels_next = 2'b10;
                default:              levels_next = 2'b00;
            endcase
        end
        countdown_next = countdown_load;
        if (countdown_load != 10'd0)
        begin
            countdown_next = countdown_load - 10'd1;
            if (countdown_next == 10'd0)
            begin
                unique case (mode)
                    cmtc_pkg::MODE_GAP_CLOSE: mode_next = cmtc_pkg::MODE_CLOSE;
                    cmtc_pkg::MODE_GAP_OPEN:  mode_next = cmtc_pkg::MODE_OPEN;
                    default:                  mode_next = cmtc_pkg::MODE_STOP;
                endcase
            end
        end
        blink_next = (blink_reg == cmtc_pkg::BLINK_LAST) ? 4'd0 : blink_reg + 4'd1;
        led_next   = flash && (blink_next >= cmtc_pkg::BLINK_ON_FROM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg <= cmtc_pkg::MODE_STOP;
            countdown_reg <= '0;
            levels_reg    <= '0;
            blink_reg     <= '0;
            led_reg       <= 1'b0;
        end
        else if (fire)
        begin
            last_seen_reg <= mode;
            countdown_reg <= countdown_next;
            levels_reg    <= levels_next;
            blink_reg     <= blink_next;
            led_reg       <= led_next;
        end
    end

    // outside a relay tick the stored levels are shown unchanged
    assign res.mode    = fire ? mode_next   : mode;
    assign res.levels  = fire ? levels_next : levels_reg;
    assign res.led     = fire ? led_next    : led_reg;
    assign res.changed = fire && changed;

endmodule

// ===== rtl/core/cmtc_checker.sv =====
module cmtc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       relay_open,
    input  logic       relay_close,
    input  logic       leds_on,
    input  logic [2:0] motor_mode,
    input  logic       state_changed,
    input  logic       restart_request
);

    // a stalled result holds its mode, relay and led outputs
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(motor_mode)
            && $stable(relay_open) && $stable(relay_close) && $stable(leds_on))
        else $error("stalled result changed");

    // relays never drive both directions
    a_relay_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(relay_open && relay_close))
        else $error("both relays on");

    // a change report and a restart request come from different tick kinds
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(state_changed && restart_request))
        else $error("change and restart in one item");

    // motor mode stays within the defined codes
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_mode <= cmtc_pkg::MODE_GAP_CLOSE))
        else $error("motor mode out of range");

endmodule

bind curtain_motor_touch_controller cmtc_checker u_cmtc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .relay_open      (relay_open),
    .relay_close     (relay_close),
    .leds_on         (leds_on),
    .motor_mode      (motor_mode),
    .state_changed   (state_changed),
    .restart_request (restart_request)
);
